// ===== design/sfagr_pkg.sv =====
// Shared types and constants of the scaled font atlas glyph renderer.
`default_nettype none

package sfagr_pkg;

  localparam int GLYPH_ROWS     = 14;
  localparam int GLYPH_COLS     = 8;
  localparam int CELLS_ACROSS   = 16;
  localparam int CELL_W         = GLYPH_COLS + 1;
  localparam int CELL_H         = GLYPH_ROWS + 1;
  localparam int MAX_SCALE      = 4;
  localparam int IDX_W          = 18;

  typedef enum logic [1:0] {
    CFG_FRAME_BASE  = 2'd0,
    CFG_LINE_PITCH  = 2'd1,
    CFG_PIXEL_BYTES = 2'd2,
    CFG_ATLAS_WIDTH = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MASK,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [15:0] line_pitch;
    logic [2:0]  pixel_bytes;
    logic [10:0] atlas_width;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [14:0]      load_idx;
    logic             load_bit;
    logic [31:0]      row_addr;
    logic [IDX_W-1:0] rowbase;
    logic [23:0]      color;
    logic [2:0]       scale;
  } qent_t;

endpackage

`default_nettype wire

// ===== design/sfagr_front.sv =====
// Front end: accepts requests, clamps the scale and precomputes addresses.
`default_nettype none

module sfagr_front
  import sfagr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [14:0] atlas_index_i,
  input  wire logic [7:0]  atlas_value_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [23:0] ink_color_i,
  input  wire logic [2:0]  magnify_i,
  input  wire logic [6:0]  char_code_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output qent_t            entry_o
);

  logic             valid_q;
  op_e              op_q;
  logic [14:0]      idx_q;
  logic             bit_q;
  logic [31:0]      pyp_q;
  logic [18:0]      xoff_q;
  logic [IDX_W-1:0] gyw_q;
  logic [7:0]       gx_q;
  logic [23:0]      color_q;
  logic [2:0]       scale_q;

  logic             take;
  logic [2:0]       scale_d;
  logic [7:0]       gx_d;
  logic [6:0]       gy_d;

  assign take       = !valid_q || !q_full_i;
  assign in_stall_o = !take;
  assign push_o     = valid_q && !q_full_i;

  always_comb begin
    if (magnify_i == 3'd0) begin
      scale_d = 3'd1;
    end else if (magnify_i > 3'(MAX_SCALE)) begin
      scale_d = 3'(MAX_SCALE);
    end else begin
      scale_d = magnify_i;
    end
    gx_d = 8'(char_code_i[3:0]) * 8'(CELL_W) + 8'd1;
    gy_d = 7'(char_code_i[6:4]) * 7'(CELL_H);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      op_q    <= op_e'(operation_i);
      idx_q   <= atlas_index_i;
      bit_q   <= |atlas_value_i;
      pyp_q   <= {16'b0, pos_y_i} * {16'b0, cfg_i.line_pitch};
      xoff_q  <= 19'(pos_x_i) * 19'(cfg_i.pixel_bytes);
      gyw_q   <= IDX_W'(gy_d) * IDX_W'(cfg_i.atlas_width);
      gx_q    <= gx_d;
      color_q <= ink_color_i;
      scale_q <= scale_d;
    end
  end

  always_comb begin
    entry_o.op       = op_q;
    entry_o.load_idx = idx_q;
    entry_o.load_bit = bit_q;
    entry_o.row_addr = cfg_i.frame_base + pyp_q + 32'(xoff_q);
    entry_o.rowbase  = gyw_q + IDX_W'(gx_q);
    entry_o.color    = color_q;
    entry_o.scale    = scale_q;
  end

endmodule

`default_nettype wire

// ===== design/sfagr_queue.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none

module sfagr_queue
  import sfagr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output qent_t      head_o
);

  qent_t      ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/sfagr_back.sv =====
// Back end: banked atlas memory, glyph row fetch and row result sequencer.
`default_nettype none

module sfagr_back
  import sfagr_pkg::*;
#(
  parameter int ATLAS_PIXELS = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        q_valid_i,
  input  wire qent_t       head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      row_address_o,
  output logic [7:0]       column_mask_o,
  output logic [2:0]       cell_width_o,
  output logic [23:0]      write_color_o,
  output logic             final_row_o
);

  localparam int BANK_DEPTH = (ATLAS_PIXELS + GLYPH_COLS - 1) / GLYPH_COLS;
  localparam int BA_W       = $clog2(BANK_DEPTH);

  back_state_e      state_q, state_d;
  logic [3:0]       row_q, row_d;
  logic [1:0]       sub_q, sub_d;
  logic [IDX_W-1:0] rowbase_q, rowbase_d;
  logic [31:0]      addr_q, addr_d;
  logic [7:0]       mask_q, mask_d;
  logic [23:0]      color_q, color_d;
  logic [2:0]       scale_q, scale_d;

  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_addr_q, out_addr_d;
  logic [7:0]       out_mask_q, out_mask_d;
  logic [2:0]       out_width_q, out_width_d;
  logic [23:0]      out_color_q, out_color_d;
  logic             out_final_q, out_final_d;

  logic             rd_en;
  logic [IDX_W-1:0] rd_base;
  logic [31:0]      base_word;
  logic [BA_W-1:0]  rd_addr [GLYPH_COLS];
  logic [7:0]       inr_c;
  logic [7:0]       inr_q;
  logic [2:0]       sh_q;
  wire  [7:0]       rd_data;
  logic [7:0]       mask_c;

  logic             wr_en;
  logic [BA_W-1:0]  wr_addr;
  logic [2:0]       wr_bank;

  logic             out_free;
  logic             last_sub;
  logic             last_row;

  assign wr_en   = pop_o && (head_i.op == OP_LOAD)
                   && (32'(head_i.load_idx) < 32'(ATLAS_PIXELS));
  assign wr_addr = BA_W'(32'(head_i.load_idx) >> 3);
  assign wr_bank = head_i.load_idx[2:0];

  always_comb begin
    base_word = 32'(rd_base) >> 3;
    for (int b = 0; b < GLYPH_COLS; b++) begin
      rd_addr[b] = BA_W'(base_word + ((3'(b) < rd_base[2:0]) ? 32'd1 : 32'd0));
      inr_c[b]   = (32'(rd_base) + 32'(b)) < 32'(ATLAS_PIXELS);
    end
  end

  for (genvar b = 0; b < GLYPH_COLS; b++) begin : g_bank
    logic mem [BANK_DEPTH];
    logic rd_bit_q;

    always_ff @(posedge clk_i) begin
      if (wr_en && (wr_bank == 3'(b))) begin
        mem[wr_addr] <= head_i.load_bit;
      end
      if (rd_en) begin
        rd_bit_q <= mem[rd_addr[b]];
      end
    end

    assign rd_data[b] = rd_bit_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      inr_q <= inr_c;
      sh_q  <= rd_base[2:0];
    end
  end

  always_comb begin
    for (int i = 0; i < GLYPH_COLS; i++) begin
      mask_c[i] = rd_data[3'(sh_q + 3'(i))] & inr_q[i];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_sub = (sub_q == 2'(scale_q - 3'd1));
  assign last_row = (row_q == 4'(GLYPH_ROWS - 1));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    sub_d       = sub_q;
    rowbase_d   = rowbase_q;
    addr_d      = addr_q;
    mask_d      = mask_q;
    color_d     = color_q;
    scale_d     = scale_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_addr_d  = out_addr_q;
    out_mask_d  = out_mask_q;
    out_width_d = out_width_q;
    out_color_d = out_color_q;
    out_final_d = out_final_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_base     = rowbase_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          if (head_i.op == OP_DRAW) begin
            rd_en     = 1'b1;
            rd_base   = head_i.rowbase;
            rowbase_d = head_i.rowbase + IDX_W'(cfg_i.atlas_width);
            addr_d    = head_i.row_addr;
            color_d   = head_i.color;
            scale_d   = head_i.scale;
            row_d     = 4'd0;
            sub_d     = 2'd0;
            state_d   = BK_MASK;
          end
        end
      end
      BK_MASK: begin
        mask_d    = mask_c;
        rd_en     = 1'b1;
        rowbase_d = rowbase_q + IDX_W'(cfg_i.atlas_width);
        state_d   = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = addr_q;
          out_mask_d  = mask_q;
          out_width_d = scale_q;
          out_color_d = color_q;
          out_final_d = last_sub && last_row;
          addr_d      = addr_q + 32'(cfg_i.line_pitch);
          if (last_sub) begin
            sub_d  = 2'd0;
            row_d  = row_q + 4'd1;
            mask_d = mask_c;
            if (last_row) begin
              state_d = BK_IDLE;
            end else begin
              rd_en     = 1'b1;
              rowbase_d = rowbase_q + IDX_W'(cfg_i.atlas_width);
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= 4'd0;
      sub_q       <= 2'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
      sub_q       <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rowbase_q   <= rowbase_d;
    addr_q      <= addr_d;
    mask_q      <= mask_d;
    color_q     <= color_d;
    scale_q     <= scale_d;
    out_addr_q  <= out_addr_d;
    out_mask_q  <= out_mask_d;
    out_width_q <= out_width_d;
    out_color_q <= out_color_d;
    out_final_q <= out_final_d;
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = out_addr_q;
  assign column_mask_o = out_mask_q;
  assign cell_width_o  = out_width_q;
  assign write_color_o = out_color_q;
  assign final_row_o   = out_final_q;

endmodule

`default_nettype wire

// ===== design/scaled_font_atlas_glyph_renderer.sv =====
// Top level of the scaled font atlas glyph renderer with its configuration registers.
//
// Requests enter on the input channel (in_valid_i, in_stall_o) and row results
// leave on the output channel (out_valid_o, out_stall_i). A load request writes
// one atlas pixel and gives no result. A draw request gives 14 * scale row
// results, top row first, with final_row_o set on the last one.
// A request passes an input register and a two-entry queue before the back end
// takes it; a draw then passes the bank read registers, the mask register and the
// output register. A load leaves the back end idle. A draw occupies the back end
// until its last row result is registered: one atlas row fetch from the eight-bank
// memory is overlapped with the emission of the previous glyph row, and one row
// result leaves per cycle while the receiver does not stall. Reset clears the queue,
// the control state and the output register and loads the register defaults; the
// atlas memory holds no defined value until written. While the receiver stalls, the
// output register holds its result, the back end waits, and once the queue fills the
// input channel stalls as well. Registers are written via cfg_we_i, cfg_idx_i and
// cfg_wdata_i, by the user only while idle; the block does not enforce this.
`default_nettype none

module scaled_font_atlas_glyph_renderer
  import sfagr_pkg::*;
#(
  parameter int ATLAS_PIXELS = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [14:0] atlas_index_i,
  input  wire logic [7:0]  atlas_value_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [23:0] ink_color_i,
  input  wire logic [2:0]  magnify_i,
  input  wire logic [6:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      row_address_o,
  output logic [7:0]       column_mask_o,
  output logic [2:0]       cell_width_o,
  output logic [23:0]      write_color_o,
  output logic             final_row_o
);

  cfg_t  cfg_q;
  logic  push;
  qent_t entry;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  qent_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base  <= 32'd0;
      cfg_q.line_pitch  <= 16'd3072;
      cfg_q.pixel_bytes <= 3'd3;
      cfg_q.atlas_width <= 11'd145;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FRAME_BASE:  cfg_q.frame_base  <= cfg_wdata_i;
        CFG_LINE_PITCH:  cfg_q.line_pitch  <= cfg_wdata_i[15:0];
        CFG_PIXEL_BYTES: cfg_q.pixel_bytes <= cfg_wdata_i[2:0];
        CFG_ATLAS_WIDTH: cfg_q.atlas_width <= cfg_wdata_i[10:0];
        default: begin
        end
      endcase
    end
  end

  sfagr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .atlas_index_i (atlas_index_i),
    .atlas_value_i (atlas_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .ink_color_i   (ink_color_i),
    .magnify_i     (magnify_i),
    .char_code_i   (char_code_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (entry)
  );

  sfagr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .head_o  (head)
  );

  sfagr_back #(
    .ATLAS_PIXELS (ATLAS_PIXELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_address_o (row_address_o),
    .column_mask_o (column_mask_o),
    .cell_width_o  (cell_width_o),
    .write_color_o (write_color_o),
    .final_row_o   (final_row_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_scaled_font_atlas_glyph_renderer.sv =====
// Self-checking testbench of the scaled font atlas glyph renderer with a row scoreboard.
`timescale 1ns / 1ps

module tb_scaled_font_atlas_glyph_renderer;
  import sfagr_pkg::*;

  localparam int ATLAS_DEPTH = 32768;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    op_e         op;
    logic [14:0] index;
    logic [7:0]  value;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [23:0] color;
    logic [2:0]  magnify;
    logic [6:0]  code;
  } glyph_request_t;

  typedef struct {
    logic [31:0] address;
    logic [7:0]  mask;
    logic [2:0]  width;
    logic [23:0] color;
    logic        last;
  } glyph_row_t;

  class row_scoreboard;
    int unsigned frame_base;
    int unsigned line_pitch;
    int unsigned pixel_bytes;
    int unsigned atlas_width;
    bit ink [ATLAS_DEPTH];
    glyph_row_t expected_rows[$];
    int unsigned errors;

    function new();
      frame_base  = 0;
      line_pitch  = 3072;
      pixel_bytes = 3;
      atlas_width = 145;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] value);
      case (idx)
        CFG_FRAME_BASE:  frame_base  = value;
        CFG_LINE_PITCH:  line_pitch  = 32'(value[15:0]);
        CFG_PIXEL_BYTES: pixel_bytes = 32'(value[2:0]);
        CFG_ATLAS_WIDTH: atlas_width = 32'(value[10:0]);
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_request(glyph_request_t r);
      int unsigned scale, gy, gx, xoff, rowbase, line_no, total, n, code_v;
      logic [7:0] mask;
      glyph_row_t row;
      if (r.op == OP_LOAD) begin
        ink[r.index] = (r.value != 0);
        return;
      end
      scale = 32'(r.magnify);
      if (scale == 0) scale = 1;
      if (scale > MAX_SCALE) scale = MAX_SCALE;
      code_v = 32'(r.code);
      gy = (code_v / CELLS_ACROSS) * CELL_H;
      gx = (code_v % CELLS_ACROSS) * CELL_W + 1;
      total = GLYPH_ROWS * scale;
      xoff = 32'(r.pos_x) * pixel_bytes;
      n = 0;
      for (int j = 0; j < GLYPH_ROWS; j++) begin
        mask = '0;
        rowbase = (gy + j) * atlas_width + gx;
        for (int i = 0; i < GLYPH_COLS; i++) begin
          if (rowbase + i < ATLAS_DEPTH) mask[i] = ink[rowbase + i];
        end
        for (int k = 0; k < scale; k++) begin
          line_no = 32'(r.pos_y) + j * scale + k;
          row.address = frame_base + line_no * line_pitch + xoff;
          row.mask = mask;
          row.width = scale[2:0];
          row.color = r.color;
          row.last = (n + 1 == total);
          expected_rows.push_back(row);
          n++;
        end
      end
    endfunction

    task check_row(glyph_row_t got);
      glyph_row_t want;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("row at %h arrived with none expected", got.address));
        return;
      end
      want = expected_rows.pop_front();
      if (got.address !== want.address)
        report_mismatch($sformatf("row_address got %h want %h", got.address, want.address));
      if (got.mask !== want.mask)
        report_mismatch($sformatf("column_mask got %h want %h at %h",
                                  got.mask, want.mask, want.address));
      if (got.width !== want.width)
        report_mismatch($sformatf("cell_width got %0d want %0d", got.width, want.width));
      if (got.color !== want.color)
        report_mismatch($sformatf("write_color got %h want %h", got.color, want.color));
      if (got.last !== want.last)
        report_mismatch($sformatf("final_row got %b want %b at %h",
                                  got.last, want.last, want.address));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        operation_i   = 1'b0;
  logic [14:0] atlas_index_i = '0;
  logic [7:0]  atlas_value_i = '0;
  logic [15:0] pos_x_i       = '0;
  logic [15:0] pos_y_i       = '0;
  logic [23:0] ink_color_i   = '0;
  logic [2:0]  magnify_i     = '0;
  logic [6:0]  char_code_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] row_address_o;
  logic [7:0]  column_mask_o;
  logic [2:0]  cell_width_o;
  logic [23:0] write_color_o;
  logic        final_row_o;

  row_scoreboard sb;
  bit            loaded_map [ATLAS_DEPTH];
  bit            gaps_on   = 1'b1;
  bit            stalls_on = 1'b1;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;

  scaled_font_atlas_glyph_renderer #(
    .ATLAS_PIXELS(ATLAS_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .atlas_index_i (atlas_index_i),
    .atlas_value_i (atlas_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .ink_color_i   (ink_color_i),
    .magnify_i     (magnify_i),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_address_o (row_address_o),
    .column_mask_o (column_mask_o),
    .cell_width_o  (cell_width_o),
    .write_color_o (write_color_o),
    .final_row_o   (final_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 24);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(99) < 30) begin
      out_stall_i <= 1'b1;
      stall_left  <= idle_length();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    glyph_row_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.address = row_address_o;
      got.mask    = column_mask_o;
      got.width   = cell_width_o;
      got.color   = write_color_o;
      got.last    = final_row_o;
      sb.check_row(got);
    end
  end

  function automatic glyph_request_t random_fields();
    glyph_request_t r;
    r.op      = op_e'($urandom_range(0, 1));
    r.index   = 15'($urandom_range(0, ATLAS_DEPTH - 1));
    r.value   = 8'($urandom_range(0, 255));
    r.pos_x   = 16'($urandom_range(0, 65535));
    r.pos_y   = 16'($urandom_range(0, 65535));
    r.color   = 24'($urandom_range(0, 24'hFFFFFF));
    r.magnify = 3'($urandom_range(0, 7));
    r.code    = 7'($urandom_range(0, 127));
    return r;
  endfunction

  task automatic send_request(glyph_request_t r);
    int unsigned gap;
    operation_i   <= r.op;
    atlas_index_i <= r.index;
    atlas_value_i <= r.value;
    pos_x_i       <= r.pos_x;
    pos_y_i       <= r.pos_y;
    ink_color_i   <= r.color;
    magnify_i     <= r.magnify;
    char_code_i   <= r.code;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    gap = gaps_on ? idle_length() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Loads the atlas pixels that a glyph's rows read, skipping indices past the atlas.
  task automatic load_glyph(logic [6:0] code, int row_lo, int row_hi, int pct, bit overwrite);
    glyph_request_t r;
    int unsigned idx, code_v;
    code_v = 32'(code);
    for (int j = row_lo; j <= row_hi; j++) begin
      for (int i = 0; i < GLYPH_COLS; i++) begin
        idx = ((code_v / CELLS_ACROSS) * CELL_H + j) * sb.atlas_width
              + (code_v % CELLS_ACROSS) * CELL_W + 1 + i;
        if (idx < ATLAS_DEPTH && (overwrite || !loaded_map[idx])) begin
          r = random_fields();
          r.op = OP_LOAD;
          r.index = idx[14:0];
          r.value = ($urandom_range(99) < pct) ? 8'($urandom_range(1, 255)) : 8'd0;
          send_request(r);
          loaded_map[idx] = 1'b1;
        end
      end
    end
  endtask

  task automatic draw_glyph(glyph_request_t r, int pct);
    load_glyph(r.code, 0, GLYPH_ROWS - 1, pct, 1'b0);
    r.op = OP_DRAW;
    send_request(r);
  endtask

  task automatic wait_idle();
    int unsigned guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d expected rows never arrived", sb.pending()));
      sb.expected_rows.delete();
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] pitch, logic [31:0] pbytes,
                           logic [31:0] awidth);
    wait_idle();
    write_reg(CFG_FRAME_BASE, base);
    write_reg(CFG_LINE_PITCH, pitch);
    write_reg(CFG_PIXEL_BYTES, pbytes);
    write_reg(CFG_ATLAS_WIDTH, awidth);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Draws stay on four glyph cells so that narrow atlases share most of their pixels.
  task automatic random_requests(int count);
    glyph_request_t r;
    int unsigned pick, row;
    for (int n = 0; n < count; n++) begin
      if (n % 8 == 0) begin
        gaps_on   = ($urandom_range(3) != 0);
        stalls_on <= ($urandom_range(3) != 0);
      end
      r = random_fields();
      r.code = 7'(16 * $urandom_range(0, 1) + $urandom_range(0, 1));
      pick = $urandom_range(99);
      row = $urandom_range(0, GLYPH_ROWS - 1);
      if (pick < 70) begin
        draw_glyph(r, $urandom_range(0, 100));
      end else if (pick < 90) begin
        r.op = OP_LOAD;
        r.index = 15'($urandom_range(0, 127));
        send_request(r);
        loaded_map[r.index] = 1'b1;
      end else begin
        load_glyph(r.code, row, row, $urandom_range(0, 100), 1'b1);
      end
    end
  endtask

  initial begin
    glyph_request_t r;
    logic [2:0] scales [5];
    scales = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd3};
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r = random_fields();
    r.code = 7'd127;
    r.pos_x = 16'hFFFF;
    r.pos_y = 16'hFFFF;
    r.color = 24'hFFFFFF;
    r.magnify = 3'd4;
    load_glyph(r.code, 0, GLYPH_ROWS - 1, 50, 1'b1);
    draw_glyph(r, 50);

    foreach (scales[s]) begin
      r = random_fields();
      r.code = 7'd127;
      r.magnify = scales[s];
      draw_glyph(r, 50);
    end

    load_glyph(7'd127, 3, 3, 0, 1'b1);
    r = random_fields();
    r.code = 7'd127;
    r.magnify = 3'd2;
    draw_glyph(r, 50);

    // At the widest atlas the last cell row lies past the atlas, and the second
    // cell row runs off its end partway through a glyph row.
    configure(32'h0000_1000, 640, 4, 2047);
    r = random_fields();
    r.code = 7'd127;
    r.magnify = 3'd4;
    draw_glyph(r, 50);
    r = random_fields();
    r.code = 7'd17;
    draw_glyph(r, 50);

    configure(32'hFFFF_FFFF, 65535, 7, 1);
    random_requests(16);

    configure($urandom, 0, 0, 0);
    random_requests(16);

    configure($urandom, $urandom_range(1, 65535), $urandom_range(1, 4), 3);
    random_requests(16);

    wait_idle();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sfagr_pkg.sv
design/sfagr_front.sv
design/sfagr_queue.sv
design/sfagr_back.sv
design/scaled_font_atlas_glyph_renderer.sv
dv/tb_scaled_font_atlas_glyph_renderer.sv
